### src/two_walker_ordered_visit_dp_macros.svh
// Assertion macros for the two-walker ordered visit block.
`ifndef TWO_WALKER_ORDERED_VISIT_DP_MACROS_SVH
`define TWO_WALKER_ORDERED_VISIT_DP_MACROS_SVH

`ifndef SYNTHESIS

`define TWOVD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

`define TWOVD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`define TWOVD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define TWOVD_ASSERT_IMPL(label, ante, cons)
`define TWOVD_ASSERT_NEXT(label, ante, cons)
`define TWOVD_ASSERT_NEVER(label, cond)

`endif

`endif

### src/twovd_pkg.sv
// Shared types and constants for the two-walker ordered visit block.
`default_nettype none
package twovd_pkg;

	localparam int FIELD_W   = 16;
	localparam int COST_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_START_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_A_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_B_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_B_Y = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

### src/twovd_dist.sv
// Manhattan distance between two points.
`default_nettype none
module twovd_dist #(
	parameter int W = 16
) (
	input  logic [W-1:0] ax,
	input  logic [W-1:0] ay,
	input  logic [W-1:0] bx,
	input  logic [W-1:0] by,
	output logic [W:0]   span
);
	logic [W-1:0] dx;
	logic [W-1:0] dy;

	assign dx   = (ax > bx) ? (ax - bx) : (bx - ax);
	assign dy   = (ay > by) ? (ay - by) : (by - ay);
	assign span = {1'b0, dx} + {1'b0, dy};

endmodule
`default_nettype wire

### src/two_walker_ordered_visit_dp.sv
// Top level: two-walker ordered visit cost, table held in block memories.
//
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// shop      in         shop_valid/shop_stall shop_x, shop_y, final_shop
// cost      out        cost_valid/cost_stall total_cost
//
// A shop reads the point and cost memories once per live entry, n entries for
// the n-th shop of a problem (first = 1), then the pipeline drains.
// Reset clears control and start registers; the memories need no clearing pass.
// The result register lets a new shop transfer while a total waits; only the
// final step of a later problem holds when the result has not yet gone.
`default_nettype none
`include "two_walker_ordered_visit_dp_macros.svh"
module two_walker_ordered_visit_dp #(
	parameter int MAX_SHOPS  = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [twovd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twovd_pkg::FIELD_W-1:0]  cfg_data,
	input  logic                           shop_valid,
	output logic                           shop_stall,
	input  logic [twovd_pkg::FIELD_W-1:0]  shop_x,
	input  logic [twovd_pkg::FIELD_W-1:0]  shop_y,
	input  logic                           final_shop,
	output logic                           cost_valid,
	input  logic                           cost_stall,
	output logic [twovd_pkg::COST_W-1:0]   total_cost
);
	import twovd_pkg::*;

	localparam int CB = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int DW = CB + 1;
	localparam int AW = (MAX_SHOPS > 1) ? $clog2(MAX_SHOPS) : 1;
	localparam int NW = $clog2(MAX_SHOPS + 1);
	localparam logic [NW-1:0] LAST_N = NW'(MAX_SHOPS);

	state_t state_q, state_d;

	logic [CB-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic [CB-1:0] prev_x_q, prev_y_q, shop_x_q, shop_y_q;
	logic          last_q;
	logic [NW-1:0] seen_q, rd_q, n_next;
	logic [DW-1:0] step_q, step_d, dist_e;

	logic [2*CB-1:0]   pt_mem [MAX_SHOPS];
	logic [COST_W-1:0] cost_mem [MAX_SHOPS];

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_pt_en, wr_cost_en;
	logic [AW-1:0]     wr_addr;
	logic [2*CB-1:0]   wr_pt;
	logic [COST_W-1:0] wr_cost;

	logic              v_s1, v_s2, v_s3;
	logic [AW-1:0]     addr_s1, addr_s2, addr_s3;
	logic [2*CB-1:0]   pt_s1;
	logic [COST_W-1:0] cost_s1, cost_s2;
	logic [DW-1:0]     dist_s2;
	logic [COST_W-1:0] via_s3, newc_s3;
	logic [COST_W:0]   via_sum, newc_sum;
	logic [COST_W-1:0] via_d, newc_d;
	logic [COST_W-1:0] best_q, fin_q, answer;

	logic accept, done_final, emit, append, first;
	logic cost_valid_q;
	logic [COST_W-1:0] total_cost_q;

	assign cfg_ready  = 1'b1;
	assign cost_valid = cost_valid_q;
	assign total_cost = total_cost_q;

	assign n_next     = seen_q + NW'(1);
	assign done_final = last_q || (n_next == LAST_N);
	assign first      = (seen_q == '0);
	assign answer     = (fin_q < best_q) ? fin_q : best_q;

	twovd_dist #(.W(CB)) u_step_dist (
		.ax(prev_x_q), .ay(prev_y_q), .bx(shop_x_q), .by(shop_y_q), .span(step_d)
	);

	twovd_dist #(.W(CB)) u_entry_dist (
		.ax(pt_s1[2*CB-1:CB]), .ay(pt_s1[CB-1:0]), .bx(shop_x_q), .by(shop_y_q),
		.span(dist_e)
	);

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		shop_stall = 1'b1;
		accept     = 1'b0;
		emit       = 1'b0;
		append     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = rd_q[AW-1:0];
		wr_pt_en   = 1'b0;
		wr_cost_en = 1'b0;
		wr_addr    = addr_s3;
		wr_pt      = {prev_x_q, prev_y_q};
		wr_cost    = newc_s3;
		case (state_q)
			ST_IDLE: begin
				shop_stall = 1'b0;
				if (shop_valid) begin
					accept  = 1'b1;
					state_d = ST_STEP;
					if (first) begin
						wr_pt_en   = 1'b1;
						wr_cost_en = 1'b1;
						wr_addr    = '0;
						wr_pt      = {a_x_q, a_y_q};
						wr_cost    = '0;
					end
				end
			end
			ST_STEP: begin
				state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				rd_en      = 1'b1;
				wr_cost_en = v_s3;
				if (rd_q == seen_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				wr_cost_en = v_s3;
				if (!(v_s1 || v_s2 || v_s3)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (done_final) begin
					if (!cost_valid_q || !cost_stall) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					append     = 1'b1;
					wr_pt_en   = 1'b1;
					wr_cost_en = 1'b1;
					wr_addr    = n_next[AW-1:0];
					wr_cost    = best_q;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_x_q <= '0;
			a_y_q <= '0;
			b_x_q <= '0;
			b_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_A_X: a_x_q <= cfg_data[CB-1:0];
				REG_START_A_Y: a_y_q <= cfg_data[CB-1:0];
				REG_START_B_X: b_x_q <= cfg_data[CB-1:0];
				REG_START_B_Y: b_y_q <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (accept && first) begin
			prev_x_q <= b_x_q;
			prev_y_q <= b_y_q;
		end else if (emit) begin
			seen_q   <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (append) begin
			seen_q   <= n_next;
			prev_x_q <= shop_x_q;
			prev_y_q <= shop_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shop_x_q <= shop_x[CB-1:0];
			shop_y_q <= shop_y[CB-1:0];
			last_q   <= final_shop;
		end
		if (state_q == ST_STEP) begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (state_q == ST_STEP) begin
			rd_q <= '0;
		end else if (rd_en) begin
			rd_q <= rd_q + NW'(1);
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (wr_pt_en) begin
			pt_mem[wr_addr] <= wr_pt;
		end
		if (wr_cost_en) begin
			cost_mem[wr_addr] <= wr_cost;
		end
		if (rd_en) begin
			pt_s1   <= pt_mem[rd_addr];
			cost_s1 <= cost_mem[rd_addr];
		end
	end

	// sweep pipeline
	assign via_sum  = {1'b0, cost_s2} + (COST_W + 1)'(dist_s2);
	assign newc_sum = {1'b0, cost_s2} + (COST_W + 1)'(step_q);
	assign via_d    = via_sum[COST_W] ? COST_MAX : via_sum[COST_W-1:0];
	assign newc_d   = newc_sum[COST_W] ? COST_MAX : newc_sum[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		dist_s2 <= dist_e;
		cost_s2 <= cost_s1;
		via_s3  <= via_d;
		newc_s3 <= newc_d;
		if (state_q == ST_STEP) begin
			best_q <= COST_MAX;
			fin_q  <= COST_MAX;
		end else if (v_s3) begin
			if (via_s3 < best_q) begin
				best_q <= via_s3;
			end
			if (newc_s3 < fin_q) begin
				fin_q <= newc_s3;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_valid_q <= 1'b0;
		end else if (emit) begin
			cost_valid_q <= 1'b1;
		end else if (!cost_stall) begin
			cost_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			total_cost_q <= answer;
		end
	end

	`TWOVD_ASSERT_IMPL(a_rd_in_range, rd_en, rd_q <= seen_q)
	`TWOVD_ASSERT_NEVER(a_no_rw_clash, rd_en && wr_cost_en && (rd_addr == wr_addr))
	`TWOVD_ASSERT_IMPL(a_finish_drained, state_q == ST_FINISH, !(v_s1 || v_s2 || v_s3))
	`TWOVD_ASSERT_NEXT(a_emit_clears, emit, (seen_q == '0) && cost_valid)

endmodule
`default_nettype wire
